// ===== rtl/core/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

    // Parser phases, one per field of the frame plus a drop phase.
    typedef enum logic [2:0] {
        PH_CMD     = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_CHECK   = 3'd5,
        PH_DROP    = 3'd6
    } t_phase;

    // Frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_LENGTH   = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    // Result kinds.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Width of the length limit register and its value after reset.
    localparam int unsigned LIMIT_W     = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // Depth of the queue between parser and output stage.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // One result transfer.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [15:0] data_length;
        logic [7:0]  trailer_byte;
        logic [1:0]  status;
    } t_result;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/cfd_parser.sv =====
`timescale 1ns / 1ps

module cfd_parser #(
    parameter int unsigned MAX_DATA_LEN = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cfd_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                         i_accept,
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    output logic                         o_push,
    output cfd_pkg::t_result             o_result
);
    import cfd_pkg::*;

    // Data length never exceeds the smaller of the register range and the hard bound.
    localparam int unsigned REG_MAX = (1 << LIMIT_W) - 1;
    localparam int unsigned LEN_CAP = (MAX_DATA_LEN < REG_MAX) ? MAX_DATA_LEN : REG_MAX;
    localparam int unsigned LEFT_W  = (LEN_CAP < 2) ? 1 : $clog2(LEN_CAP + 1);

    t_phase               r_phase, n_phase;
    logic [LIMIT_W-1:0]   r_limit;
    logic [7:0]           r_cmd, n_cmd;
    logic [15:0]          r_len, n_len;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic [7:0]           r_xor, n_xor;
    logic [7:0]           r_trailer, n_trailer;

    logic [15:0]          w_len;
    logic                 w_over;

    // Length as seen on the low length byte, and the limit check on it.
    assign w_len  = {r_len[15:8], i_byte};
    assign w_over = (w_len > {{(16 - LIMIT_W){1'b0}}, r_limit}) ||
                    (w_len > 16'(MAX_DATA_LEN));

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_CMD:     n_phase = i_last ? PH_CMD : PH_LEN_HI;
                PH_LEN_HI:  n_phase = i_last ? PH_CMD : PH_LEN_LO;
                PH_LEN_LO: begin
                    if (i_last) begin
                        n_phase = PH_CMD;
                    end else if (w_over) begin
                        n_phase = PH_DROP;
                    end else if (w_len == 16'd0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (i_last) begin
                        n_phase = PH_CMD;
                    end else if (r_left == LEFT_W'(1)) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_TRAILER: n_phase = i_last ? PH_CMD : PH_CHECK;
                PH_CHECK:   n_phase = i_last ? PH_CMD : PH_DROP;
                default:    n_phase = i_last ? PH_CMD : PH_DROP;
            endcase
        end
    end

    // Held fields, checksum and the result pushed for this transfer.
    always_comb begin
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_left    = r_left;
        n_xor     = r_xor;
        n_trailer = r_trailer;
        o_push    = 1'b0;
        o_result  = '0;
        if (i_accept) begin
            case (r_phase)
                PH_CMD: begin
                    n_cmd     = i_byte;
                    n_len     = '0;
                    n_trailer = '0;
                    n_left    = '0;
                    n_xor     = i_byte;
                    if (i_last) begin
                        o_push          = 1'b1;
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_SHORT;
                    end
                end
                PH_LEN_HI: begin
                    n_len = {i_byte, 8'h00};
                    n_xor = r_xor ^ i_byte;
                    if (i_last) begin
                        o_push          = 1'b1;
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_SHORT;
                    end
                end
                PH_LEN_LO: begin
                    n_len  = w_len;
                    n_xor  = r_xor ^ i_byte;
                    n_left = w_len[LEFT_W-1:0];
                    if (w_over) begin
                        o_push          = 1'b1;
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_LENGTH;
                    end else if (i_last) begin
                        o_push          = 1'b1;
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_SHORT;
                    end
                end
                PH_DATA: begin
                    n_xor  = r_xor ^ i_byte;
                    n_left = r_left - LEFT_W'(1);
                    o_push = 1'b1;
                    if (i_last) begin
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_SHORT;
                    end else begin
                        o_result.kind         = KIND_DATA;
                        o_result.payload_byte = i_byte;
                    end
                end
                PH_TRAILER: begin
                    n_trailer = i_byte;
                    n_xor     = r_xor ^ i_byte;
                    if (i_last) begin
                        o_push          = 1'b1;
                        o_result.kind   = KIND_FRAME;
                        o_result.status = ST_SHORT;
                    end
                end
                PH_CHECK: begin
                    o_push                = 1'b1;
                    o_result.kind         = KIND_FRAME;
                    o_result.command      = r_cmd;
                    o_result.data_length  = r_len;
                    o_result.trailer_byte = r_trailer;
                    o_result.status       = (r_xor == i_byte) ? ST_OK : ST_CHECKSUM;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // Control state and the limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_limit <= LIMIT_RESET;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Frame fields; each is written before it is read within a frame.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_len     <= n_len;
        r_left    <= n_left;
        r_xor     <= n_xor;
        r_trailer <= n_trailer;
    end

endmodule

// ===== rtl/core/cfd_fifo.sv =====
`timescale 1ns / 1ps

module cfd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cfd_pkg::t_result     i_wdata,
    input  logic                 i_pop,
    output cfd_pkg::t_result     o_head,
    output cfd_pkg::t_q_status   o_status
);
    import cfd_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/cfd_emitter.sv =====
`timescale 1ns / 1ps

module cfd_emitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfd_pkg::t_result     i_head,
    input  cfd_pkg::t_q_status   i_status,
    output logic                 o_pop,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [47:0]          o_data,
    output logic                 o_user
);
    import cfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Load the output register when it is empty or being taken.
    assign o_pop = !i_status.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    // Pack the result fields onto the bus.
    assign o_valid = r_valid;
    assign o_user  = r_res.kind;
    assign o_data  = {6'd0, r_res.status, r_res.trailer_byte, r_res.data_length,
                      r_res.command, r_res.payload_byte};

endmodule

// ===== rtl/core/command_frame_deframer.sv =====
`timescale 1ns / 1ps

// Command frame deframer.
// Input stream: one byte of a received buffer per transfer on s_axis, with
// s_axis_tlast on the buffer's last byte. A frame is a command byte, a
// big-endian 16-bit length, that many data bytes, a trailer byte and an XOR
// checksum byte. Output stream: m_axis_tuser 0 carries a data byte as it
// arrives; m_axis_tuser 1 closes a frame with command, length, trailer and a
// status (ok, buffer too short, length over limit, checksum error).
// The user must write the length limit through i_cfg_we / i_cfg_wdata only
// while idle; the block does not enforce this. Throughput is one byte per
// cycle: the parser takes a byte every cycle as long as the four-entry
// result queue has room. Results reach m_axis via queue and output register.
// When the receiver stalls, results wait in the queue and the output register;
// s_axis_tready drops only once the queue is full.
// Reset clears the parser to expect a command byte, empties the queue, drops
// m_axis_tvalid and sets the length limit to 256.
module command_frame_deframer #(
    parameter int unsigned MAX_DATA_LEN = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cfd_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
    input  logic                         s_axis_tlast,  // buffer_end
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] payload_byte, [15:8] command, [31:16] data_length,
    // [39:32] trailer_byte, [41:40] status, [47:42] zero
    output logic [47:0]                  m_axis_tdata,
    output logic                         m_axis_tuser   // kind
);
    import cfd_pkg::*;

    logic      w_accept;
    logic      w_push;
    logic      w_pop;
    t_result   w_result;
    t_result   w_head;
    t_q_status w_q_status;

    assign s_axis_tready = !w_q_status.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Front: frame parser.
    cfd_parser #(
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (w_push),
        .o_result    (w_result)
    );

    // Result queue between front and back.
    cfd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_result),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back: output register.
    cfd_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_q_status),
        .o_pop    (w_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // A data byte result carries nothing but the byte.
    a_data_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DATA)) |-> (m_axis_tdata[47:8] == 40'd0))
        else $error("data byte result carries frame fields");

    // A frame that passed the length check never reports a length over the bound.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_FRAME) &&
         ((m_axis_tdata[41:40] == ST_OK) || (m_axis_tdata[41:40] == ST_CHECKSUM)))
        |-> (m_axis_tdata[31:16] <= 16'(MAX_DATA_LEN)))
        else $error("reported length exceeds bound");

    // Short and length errors report zeroed frame fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_FRAME) &&
         ((m_axis_tdata[41:40] == ST_SHORT) || (m_axis_tdata[41:40] == ST_LENGTH)))
        |-> (m_axis_tdata[39:0] == 40'd0))
        else $error("error result carries frame fields");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cfd_pkg::*;

    localparam int MAX_LEN = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
    logic                s_axis_tlast = 1'b0; // buffer_end
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] payload_byte, [15:8] command, [31:16] data_length,
    // [39:32] trailer_byte, [41:40] status, [47:42] zero
    logic [47:0]         m_axis_tdata;
    logic                m_axis_tuser;        // kind

    // Parser state as the testbench tracks it.
    t_phase              parse_phase = PH_CMD;
    logic [7:0]          cmd_hold = '0;
    logic [15:0]         len_hold = '0;
    logic [15:0]         remaining = '0;
    logic [7:0]          xor_acc = '0;
    logic [7:0]          trailer_hold = '0;
    logic [LIMIT_W-1:0]  limit_reg = LIMIT_RESET;

    t_result             expected_results[$];
    int                  errors = 0;
    int                  cycle_count = 0;
    int                  bytes_sent = 0;
    int                  burst_left = 0;
    bit                  sender_idle = 1'b1;
    t_rx_mode            rx_mode = RX_ALWAYS;

    command_frame_deframer #(.MAX_DATA_LEN(MAX_LEN)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("command_frame_deframer test failed");
            $finish;
        end
    end

    // Receiver stall pattern, chosen per stretch of traffic.
    always @(posedge i_clk) begin
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (cycle_count % 4 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic t_result frame_result(input logic [1:0] st);
        t_result r;
        r = '0;
        r.kind = KIND_FRAME;
        r.status = st;
        return r;
    endfunction

    // Advance the tracked parser by one accepted byte and queue what it yields.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_result r;
        bit      emit;
        r = '0;
        emit = 1'b0;
        case (parse_phase)
            PH_CMD: begin
                cmd_hold = b;
                len_hold = '0;
                trailer_hold = '0;
                remaining = '0;
                xor_acc = b;
                if (last) begin
                    r = frame_result(ST_SHORT);
                    emit = 1'b1;
                end else begin
                    parse_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                len_hold = {b, 8'h00};
                xor_acc ^= b;
                if (last) begin
                    r = frame_result(ST_SHORT);
                    emit = 1'b1;
                    parse_phase = PH_CMD;
                end else begin
                    parse_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                len_hold = {len_hold[15:8], b};
                xor_acc ^= b;
                // An oversize length wins over a buffer ending on this byte.
                if (len_hold > limit_reg || len_hold > MAX_LEN) begin
                    r = frame_result(ST_LENGTH);
                    emit = 1'b1;
                    parse_phase = last ? PH_CMD : PH_DROP;
                end else if (last) begin
                    r = frame_result(ST_SHORT);
                    emit = 1'b1;
                    parse_phase = PH_CMD;
                end else begin
                    remaining = len_hold;
                    parse_phase = (len_hold == 0) ? PH_TRAILER : PH_DATA;
                end
            end
            PH_DATA: begin
                // A data byte that ends the buffer is not passed on.
                if (last) begin
                    r = frame_result(ST_SHORT);
                    parse_phase = PH_CMD;
                end else begin
                    xor_acc ^= b;
                    remaining = remaining - 16'd1;
                    if (remaining == 0) parse_phase = PH_TRAILER;
                    r.kind = KIND_DATA;
                    r.payload_byte = b;
                end
                emit = 1'b1;
            end
            PH_TRAILER: begin
                trailer_hold = b;
                xor_acc ^= b;
                if (last) begin
                    r = frame_result(ST_SHORT);
                    emit = 1'b1;
                    parse_phase = PH_CMD;
                end else begin
                    parse_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                r = frame_result((xor_acc == b) ? ST_OK : ST_CHECKSUM);
                r.command = cmd_hold;
                r.data_length = len_hold;
                r.trailer_byte = trailer_hold;
                emit = 1'b1;
                parse_phase = last ? PH_CMD : PH_DROP;
            end
            default: begin
                if (last) parse_phase = PH_CMD;
            end
        endcase
        if (emit) expected_results.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: tuser %0b, tdata %h", m_axis_tuser, m_axis_tdata);
            errors++;
        end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, m_axis_tuser);
            check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
            check_field("command", want.command, m_axis_tdata[15:8]);
            check_field("data_length", want.data_length, m_axis_tdata[31:16]);
            check_field("trailer_byte", want.trailer_byte, m_axis_tdata[39:32]);
            check_field("status", want.status, m_axis_tdata[41:40]);
            check_field("pad", 16'h0, m_axis_tdata[47:42]);
        end
    endtask

    // Monitor both streams at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // Send one byte, with random bursts and gaps when idling is enabled.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (sender_idle) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 4);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        bytes_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_buffer(input logic [7:0] bytes_q[$]);
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Build a frame with random content. cut >= 0 ends the buffer at that byte
    // index; junk bytes follow the checksum.
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input int cut,
                              input bit bad_sum, input int junk);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        int         data_count;
        frame_bytes = '{cmd, len[15:8], len[7:0]};
        data_count = (cut >= 0 && cut < len) ? cut : len;
        repeat (data_count) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        sum = '0;
        foreach (frame_bytes[i]) sum ^= frame_bytes[i];
        if (bad_sum) sum ^= 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        repeat (junk) frame_bytes.push_back(8'($urandom));
        if (cut >= 0 && cut < frame_bytes.size() - 1)
            frame_bytes = frame_bytes[0:cut];
        send_buffer(frame_bytes);
    endtask

    // One frame of a randomly chosen shape, sized against the current limit.
    task automatic send_random_frame();
        int          pick;
        int          allowed;
        logic [15:0] len;
        allowed = (limit_reg < MAX_LEN) ? limit_reg : MAX_LEN;
        pick = $urandom_range(0, 99);
        if (pick < 3) len = 16'(allowed);
        else if (pick < 75) len = 16'($urandom_range(0, (allowed < 8) ? allowed : 8));
        else len = 16'($urandom_range(0, (allowed < 40) ? allowed : 40));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_frame(8'($urandom), len, -1, 1'b0, 0);
        end else if (pick < 65) begin
            send_frame(8'($urandom), len, -1, 1'b1, $urandom_range(0, 2));
        end else if (pick < 77) begin
            // Buffer ends somewhere before the checksum.
            send_frame(8'($urandom), len, $urandom_range(0, len + 3), 1'b0, 0);
        end else if (pick < 87) begin
            if ($urandom_range(0, 1)) len = 16'(allowed + 1 + $urandom_range(0, 2));
            else len = 16'($urandom_range(allowed + 1, 16'hFFFF));
            send_frame(8'($urandom), len, $urandom_range(2, 12), 1'b0, 0);
        end else if (pick < 94) begin
            send_frame(8'($urandom), len, -1, 1'($urandom_range(0, 1)),
                       $urandom_range(1, 4));
        end else begin
            // Noise with random buffer ends.
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    // Hand-built buffers covering the field extremes and each way a frame ends.
    task automatic test_directed_cases();
        sender_idle = 1'b0;
        rx_mode = RX_ALWAYS;
        // Zero length, good checksum ending the buffer.
        send_buffer('{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF});
        // Length over limit on a byte that also ends the buffer.
        send_buffer('{8'h00, 8'hFF, 8'hFF});
        // A buffer of one byte.
        send_buffer('{8'h5A});
        // One data byte, bad checksum, then bytes that are dropped.
        send_buffer('{8'hA5, 8'h00, 8'h01, 8'hFF, 8'h5A, 8'hFE, 8'h11, 8'h22});
        // Buffer ends on a data byte.
        send_buffer('{8'h3C, 8'h00, 8'h02, 8'h00, 8'h77});
        // One past the hard bound, not at the buffer end.
        send_buffer('{8'h81, 8'h01, 8'h01, 8'hEE});
        wait_idle();
    endtask

    // Limit register at its extremes and around the hard bound.
    task automatic test_length_limit();
        sender_idle = 1'b1;
        rx_mode = RX_COIN;
        write_limit(9'd0);
        send_frame(8'h12, 16'd0, -1, 1'b0, 0);
        send_frame(8'h34, 16'd1, -1, 1'b0, 0);
        write_limit(9'h1FF);
        send_frame(8'h56, 16'd256, -1, 1'b0, 0);
        send_frame(8'h78, 16'd257, 5, 1'b0, 0);
        write_limit(9'd255);
        send_frame(8'h9A, 16'd255, 4, 1'b0, 0);
        send_frame(8'hBC, 16'd256, 3, 1'b0, 0);
        write_limit(LIMIT_RESET);
    endtask

    // Back-to-back bytes with the receiver always ready.
    task automatic test_full_rate();
        sender_idle = 1'b0;
        rx_mode = RX_ALWAYS;
        repeat (6) send_random_frame();
        wait_idle();
    endtask

    // Sender without gaps against a slow receiver, so the queue fills.
    task automatic test_backpressure();
        sender_idle = 1'b0;
        rx_mode = RX_SPARSE;
        repeat (6) send_random_frame();
        wait_idle();
    endtask

    // Random frames over several limit settings with random idling on both sides.
    task automatic test_random_frames();
        logic [LIMIT_W-1:0] limits[6];
        int                 start;
        limits = '{LIMIT_RESET, 9'd0, 9'h1FF, 9'($urandom_range(0, 511)), 9'd1, 9'd255};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            start = bytes_sent;
            while (bytes_sent - start < 50) begin
                sender_idle = ($urandom_range(0, 3) != 0);
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                send_random_frame();
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_length_limit();
        test_full_rate();
        test_backpressure();
        test_random_frames();
        if (errors == 0) begin
            $display("command_frame_deframer test passed");
        end else begin
            $display("command_frame_deframer test failed");
        end
        $finish;
    end

endmodule
